FILE: rtl/cfs_pkg.sv
// shared types, constants and sine table function for the crossfade selector
`timescale 1ns / 1ps
`default_nettype none
package cfs_pkg;
	localparam int SAMPLE_W = 16;
	localparam int CNT_W    = 16;
	localparam int GAIN_W   = 16;
	localparam int MIX_W    = 19;
	localparam int ACC_W    = 36;
	localparam int QUOT_W   = 29;
	localparam logic [1:0] REG_FADE_LENGTH = 2'd0;
	localparam logic [1:0] REG_FADE_SHAPE  = 2'd1;
	localparam logic REQ_FRAME  = 1'b0;
	localparam logic REQ_SELECT = 1'b1;

	typedef struct packed {
		logic start;
		logic load_div;
		logic div_step;
		logic accumulate;
		logic finish;
		logic [2:0] chan;
	} cfs_cmd_t;

	typedef struct packed {
		logic div_last;
	} cfs_status_t;

	// sine entry k of a table of the given depth, Q1.15, evaluated when the rom is filled
	function automatic logic [16:0] sine_entry(input int unsigned k, input int unsigned depth);
		logic [63:0] x, x2, t, s, q;
		int unsigned divs [6];
		divs = '{156, 110, 72, 42, 20, 6};
		x = (64'(k) * 64'd1686629713) / 64'(depth);
		x2 = (x * x) >> 30;
		t = 64'd1 << 30;
		for (int i = 0; i < 6; i++) t = (64'd1 << 30) - ((x2 * t) >> 30) / 64'(divs[i]);
		s = (x * t) >> 30;
		q = (s + 64'd16384) >> 15;
		return (q > 64'd32768) ? 17'd32768 : q[16:0];
	endfunction
endpackage
`default_nettype wire

FILE: rtl/cfs_datapath.sv
// datapath: ramp counters, restoring divider, sine rom, multiply-accumulate
`timescale 1ns / 1ps
`default_nettype none
module cfs_datapath #(
	parameter int CHANNELS = 8,
	parameter int SINE_TABLE_DEPTH = 1024
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire cfs_pkg::cfs_cmd_t cmd,
	output cfs_pkg::cfs_status_t status,
	input  wire logic [15:0] fade_length,
	input  wire logic fade_shape,
	input  wire logic [3:0] sel,
	input  wire logic [8*16-1:0] samples,
	output logic [18:0] mix
);
	import cfs_pkg::*;
	localparam int KW = $clog2(SINE_TABLE_DEPTH);
	localparam int DBITS = 15 > KW ? 15 : KW;   // quotient bits needed
	localparam int NUM_W = 16 + DBITS;

	logic [CNT_W-1:0] cnt_q [CHANNELS];
	logic [16:0] gain_q;
	logic [NUM_W-1:0] num_q;
	logic [15:0] rem_q;
	logic [DBITS:0] quo_q;
	logic [4:0] step_q;
	logic signed [ACC_W-1:0] acc_q;
	logic signed [SAMPLE_W-1:0] smp_q;
	logic [15:0] len;
	logic [15:0] c_clamp;
	logic [16:0] trial;
	logic [KW:0] kidx;
	logic [16:0] sine_rom [SINE_TABLE_DEPTH+1];
	logic signed [ACC_W-1:0] rounded;

	assign len = (fade_length == '0) ? 16'd1 : fade_length;
	assign c_clamp = (cnt_q[cmd.chan[$clog2(CHANNELS > 1 ? CHANNELS : 2)-1:0]] > len) ? len
		: cnt_q[cmd.chan[$clog2(CHANNELS > 1 ? CHANNELS : 2)-1:0]];
	assign trial = {rem_q, num_q[NUM_W-1]};
	assign status.div_last = (step_q == 5'(NUM_W - 1));
	assign kidx = quo_q[KW:0];

	// quarter-wave table, read through the gain register
	initial begin
		for (int k = 0; k <= SINE_TABLE_DEPTH; k++)
			sine_rom[k] = sine_entry(k, SINE_TABLE_DEPTH);
	end

	// counters move once per frame at start
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < CHANNELS; i++) cnt_q[i] <= '0;
		end else if (cmd.start) begin
			for (int i = 0; i < CHANNELS; i++) begin
				if (sel == 4'(i + 1)) begin
					if (cnt_q[i] < len) cnt_q[i] <= cnt_q[i] + 1'b1;
				end else if (cnt_q[i] != '0) begin
					cnt_q[i] <= cnt_q[i] - 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_div) begin
			num_q <= fade_shape ? NUM_W'(32'(c_clamp) * 32'(SINE_TABLE_DEPTH))
				: NUM_W'(32'(c_clamp) << 15);
			rem_q <= '0;
			quo_q <= '0;
			step_q <= '0;
			smp_q <= samples[cmd.chan*16 +: 16];
		end else if (cmd.div_step) begin
			num_q <= num_q << 1;
			step_q <= step_q + 1'b1;
			if (trial >= {1'b0, len}) begin
				rem_q <= 16'(trial - {1'b0, len});
				quo_q <= {quo_q[DBITS-1:0], 1'b1};
			end else begin
				rem_q <= trial[15:0];
				quo_q <= {quo_q[DBITS-1:0], 1'b0};
			end
		end
		if (cmd.div_step && status.div_last) gain_q <= '0;
		if (cmd.accumulate) gain_q <= fade_shape ? sine_rom[kidx] : 17'(quo_q);
	end

	// the product is taken in the cycle after the gain is registered
	logic accum_d_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) accum_d_q <= 1'b0;
		else accum_d_q <= cmd.accumulate;
	end

	always_ff @(posedge clk) begin
		if (cmd.start) acc_q <= '0;
		else if (accum_d_q) acc_q <= acc_q + ACC_W'(smp_q * $signed({1'b0, gain_q}));
	end

	assign rounded = (acc_q + ACC_W'(16384)) >>> 15;
	assign mix = rounded[18:0];
endmodule
`default_nettype wire

FILE: rtl/cfs_ctrl.sv
// controller: sequences channels through divider and accumulator
`timescale 1ns / 1ps
`default_nettype none
module cfs_ctrl #(
	parameter int CHANNELS = 8
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic in_beat,
	input  wire logic frame,
	output logic busy,
	output cfs_pkg::cfs_cmd_t cmd,
	input  wire cfs_pkg::cfs_status_t status,
	output logic done
);
	import cfs_pkg::*;
	typedef enum logic [2:0] {IDLE, LOAD, DIV, ACC, WAIT, FIN} state_t;
	state_t state_q;
	logic [2:0] ch_q;

	always_comb begin
		cmd = '0;
		cmd.chan = ch_q;
		cmd.start = in_beat && frame;
		cmd.load_div = (state_q == LOAD);
		cmd.div_step = (state_q == DIV);
		cmd.accumulate = (state_q == ACC);
	end
	assign busy = (state_q != IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= IDLE;
			ch_q <= '0;
			done <= 1'b0;
		end else begin
			done <= 1'b0;
			case (state_q)
				IDLE: if (in_beat && frame) begin
					ch_q <= '0;
					state_q <= LOAD;
				end
				LOAD: state_q <= DIV;
				DIV: if (status.div_last) state_q <= ACC;
				ACC: state_q <= WAIT;
				WAIT: if (ch_q == 3'(CHANNELS - 1)) begin
					state_q <= FIN;
				end else begin
					ch_q <= ch_q + 1'b1;
					state_q <= LOAD;
				end
				FIN: begin
					done <= 1'b1;
					state_q <= IDLE;
				end
				default: state_q <= IDLE;
			endcase
		end
	end
endmodule
`default_nettype wire

FILE: rtl/crossfade_channel_selector_top.sv
// top level of the crossfade channel selector
// usage:
// - s_axis beat carries a sample frame or a channel select event (tuser).
//   select events take effect at once and give no output beat; the input stays ready.
// - each frame gives one m_axis beat holding the 19-bit mix.
// - per channel: a load state (LOAD), a bit-serial restoring divider (DIV)
//   for the gain or sine index, a gain state (ACC) and a multiply-accumulate
//   state (WAIT); the channels are taken in turn.
// - a frame's beat is registered after the FIN state; the input is ready
//   again once done has dropped, so it waits until the frame is through.
// - the divider loop bounds the frame rate; one frame is in work at a time.
// - a stalled receiver holds the output beat; one more frame may finish
//   into a spare register, then the input stays low until the beat leaves.
// - reset clears counters, selection and sets fade_length 1, fade_shape 1.
// - apb registers: 0x0 fade_length, 0x4 fade_shape; pready always high.
`timescale 1ns / 1ps
`default_nettype none
module crossfade_channel_selector_top #(
	parameter int CHANNELS = 8,
	parameter int SINE_TABLE_DEPTH = 1024
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic s_tvalid,
	output logic s_tready,
	input  wire logic [135:0] s_tdata,  // select_channel[3:0], sample_0..7, zero pad
	input  wire logic s_tuser,          // req_type
	output logic m_tvalid,
	input  wire logic m_tready,
	output logic [23:0] m_tdata,        // mix_out[18:0], zero pad
	input  wire logic psel,
	input  wire logic penable,
	input  wire logic pwrite,
	input  wire logic [2:0] paddr,
	input  wire logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic pready
);
	import cfs_pkg::*;
	logic [15:0] fade_length_q;
	logic fade_shape_q;
	logic [3:0] sel_q;
	logic busy, done, in_beat;
	logic [18:0] mix;
	cfs_cmd_t cmd;
	cfs_status_t status;
	logic [1:0] reg_idx;
	logic pending_q;
	logic [18:0] pend_mix_q;

	assign pready = 1'b1;
	assign reg_idx = paddr[2] ? REG_FADE_SHAPE : REG_FADE_LENGTH;
	assign s_tready = !busy && !pending_q && !done;
	assign in_beat = s_tvalid && s_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fade_length_q <= 16'd1;
			fade_shape_q <= 1'b1;
		end else if (psel && penable && pwrite && paddr[1:0] == 2'b00) begin
			case (reg_idx)
				REG_FADE_LENGTH: fade_length_q <= pwdata[15:0];
				REG_FADE_SHAPE: fade_shape_q <= pwdata[0];
				default: ;
			endcase
		end
	end
	assign prdata = (reg_idx == REG_FADE_SHAPE) ? {31'd0, fade_shape_q} : {16'd0, fade_length_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) sel_q <= '0;
		else if (in_beat && s_tuser == REQ_SELECT)
			sel_q <= (s_tdata[3:0] > 4'(CHANNELS)) ? 4'(CHANNELS) : s_tdata[3:0];
	end

	// samples held for the whole frame
	logic [127:0] samples_q;
	always_ff @(posedge clk) if (in_beat) samples_q <= s_tdata[131:4];

	cfs_ctrl #(.CHANNELS(CHANNELS)) u_ctrl (
		.clk, .arst_n, .in_beat, .frame(s_tuser == REQ_FRAME), .busy,
		.cmd, .status, .done(done)
	);

	cfs_datapath #(.CHANNELS(CHANNELS), .SINE_TABLE_DEPTH(SINE_TABLE_DEPTH)) u_dp (
		.clk, .arst_n, .cmd, .status, .fade_length(fade_length_q),
		.fade_shape(fade_shape_q), .sel(sel_q), .samples(samples_q), .mix
	);

	// output register with one spare slot; input waits while the spare is full
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid <= 1'b0;
			pending_q <= 1'b0;
		end else begin
			if (m_tvalid && m_tready) m_tvalid <= 1'b0;
			if (done) begin
				if (m_tvalid && !m_tready) pending_q <= 1'b1;
				else m_tvalid <= 1'b1;
			end else if (pending_q && (!m_tvalid || m_tready)) begin
				pending_q <= 1'b0;
				m_tvalid <= 1'b1;
			end
		end
	end
	always_ff @(posedge clk) begin
		if (done) pend_mix_q <= mix;
		if (done && !(m_tvalid && !m_tready)) m_tdata <= {5'd0, mix};
		else if (!done && pending_q && (!m_tvalid || m_tready)) m_tdata <= {5'd0, pend_mix_q};
	end

`ifndef SYNTH
	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid) else $error("output beat dropped");
	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		busy |-> !s_tready) else $error("input taken while busy");
	a_sel_range: assert property (@(posedge clk) disable iff (!arst_n)
		sel_q <= 4'(CHANNELS)) else $error("selection out of range");
`endif
endmodule
`default_nettype wire

FILE: tb/sv/tb_crossfade_channel_selector_top.sv
// testbench for the crossfade channel selector: directed and random frames checked against a local gain model
`timescale 1ns / 1ps
`default_nettype none
module tb_crossfade_channel_selector_top;
	import cfs_pkg::*;

	localparam int NCH = 8;
	localparam int DEPTH = 1024;
	localparam int WATCHDOG = 20000;

	logic clk = 1'b0;
	logic arst_n = 1'b1;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [135:0] s_tdata = '0;  // select_channel[3:0], sample_0..7, zero pad
	logic s_tuser = 1'b0;        // req_type
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [23:0] m_tdata;        // mix_out[18:0], zero pad
	logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
	logic [2:0] paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic pready;

	crossfade_channel_selector_top dut (.*);

	initial forever #6 clk = ~clk;

	// model state
	logic [15:0] len_reg = 16'd1;
	logic shape_reg = 1'b1;
	logic [3:0] sel_ch = '0;
	logic [15:0] ramp [NCH];
	logic [16:0] sine_lut [DEPTH+1];
	logic signed [18:0] mix_q [$];

	int errors = 0;
	int idle_cycles = 0;
	bit rx_hold = 1'b0;
	bit rx_calm = 1'b0;
	bit tx_calm = 1'b0;

	function automatic logic [16:0] sine_of(int unsigned k);
		logic [63:0] x, x2, t, s, q;
		int unsigned dv [6];
		dv = '{156, 110, 72, 42, 20, 6};
		x = (64'(k) * 64'd1686629713) / 64'(DEPTH);
		x2 = (x * x) >> 30;
		t = 64'd1 << 30;
		for (int i = 0; i < 6; i++) t = (64'd1 << 30) - ((x2 * t) >> 30) / 64'(dv[i]);
		s = (x * t) >> 30;
		q = (s + 64'd16384) >> 15;
		return (q > 64'd32768) ? 17'd32768 : q[16:0];
	endfunction

	initial begin
		for (int k = 0; k <= DEPTH; k++) sine_lut[k] = sine_of(k);
		for (int i = 0; i < NCH; i++) ramp[i] = '0;
	end

	function automatic logic signed [18:0] mix_frame(logic [135:0] d);
		longint acc, q;
		int unsigned l, c;
		logic [16:0] g;
		logic signed [15:0] smp;
		acc = 0;
		l = (len_reg == 0) ? 1 : len_reg;
		for (int i = 0; i < NCH; i++) begin
			c = ramp[i];
			if (sel_ch == i + 1 && c < l) c++;
			else if (sel_ch != i + 1 && c > 0) c--;
			ramp[i] = c[15:0];
			if (c > l) c = l;
			if (shape_reg) g = sine_lut[(longint'(c) * DEPTH) / l];
			else g = 17'((longint'(c) << 15) / l);
			smp = d[4 + 16*i +: 16];
			acc += longint'(smp) * longint'(g);
		end
		q = (acc + 16384) >>> 15;
		if (q > 262143) q = 262143;
		if (q < -262144) q = -262144;
		return q[18:0];
	endfunction

	always @(posedge clk) begin
		if (m_tvalid && m_tready) begin
			if (mix_q.size() == 0) begin
				$display("%0t: unexpected mix beat %0d", $time, $signed(m_tdata[18:0]));
				errors++;
			end else begin
				logic signed [18:0] want;
				want = mix_q.pop_front();
				if (m_tdata[18:0] !== want || m_tdata[23:19] !== '0) begin
					$display("%0t: mix_out expected %0d actual %0d (raw %h)", $time, want,
						$signed(m_tdata[18:0]), m_tdata);
					errors++;
				end
			end
		end
	end

	// receiver stalls: random, calm stretch, or a long hold-off
	initial begin
		int n;
		forever begin
			@(posedge clk);
			if (rx_hold) begin
				m_tready <= 1'b0;
				for (n = 0; n < 3000; n++) @(posedge clk);
				rx_hold = 1'b0;
			end
			m_tready <= rx_calm || ($urandom_range(99) >= 18);
		end
	end

	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || psel) idle_cycles <= 0;
		else idle_cycles <= idle_cycles + 1;
		if (idle_cycles > WATCHDOG) begin
			$display("** crossfade_channel_selector_top: FAILED **");
			$finish;
		end
	end

	// tvalid stays high after the last beat until the next send, idle or drain
	task automatic send_item(logic req, logic [3:0] ch, logic [127:0] smp);
		while (!tx_calm && $urandom_range(99) < 18) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= req;
		s_tdata <= {smp, ch};
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		if (req == REQ_SELECT) sel_ch = (ch > NCH) ? 4'(NCH) : ch;
		else mix_q.push_back(mix_frame({smp, ch}));
	endtask

	task automatic drain();
		s_tvalid <= 1'b0;
		while (mix_q.size() != 0) @(posedge clk);
		repeat (400) @(posedge clk);
	endtask

	task automatic write_reg(logic [1:0] idx, logic [31:0] val);
		drain();
		psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
		paddr <= {idx, 1'b0} << 1; pwdata <= val;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
		if (idx == REG_FADE_LENGTH) len_reg = val[15:0];
		else if (idx == REG_FADE_SHAPE) shape_reg = val[0];
	endtask

	function automatic logic [127:0] rnd_samples();
		logic [127:0] r;
		for (int i = 0; i < 4; i++) r[32*i +: 32] = $urandom;
		return r;
	endfunction

	function automatic logic [127:0] fill(logic [15:0] v);
		return {8{v}};
	endfunction

	task automatic test_extremes();
		send_item(REQ_FRAME, 4'd0, fill(16'h7fff));
		send_item(REQ_SELECT, 4'd1, '0);
		send_item(REQ_FRAME, 4'd0, fill(16'h7fff));
		send_item(REQ_FRAME, 4'd5, fill(16'h8000));
		send_item(REQ_SELECT, 4'd15, '0);  // clamped to last channel
		send_item(REQ_FRAME, 4'hf, fill(16'h8000));
		send_item(REQ_FRAME, 4'd0, fill(16'hffff));
		send_item(REQ_SELECT, 4'd9, '0);
		send_item(REQ_FRAME, 4'd0, fill(16'h7fff));
		send_item(REQ_SELECT, 4'd0, '0);
		send_item(REQ_FRAME, 4'd0, fill(16'h7fff));
	endtask

	task automatic test_fades(logic [15:0] l, logic shp, int frames);
		write_reg(REG_FADE_LENGTH, {16'hdead, l});
		write_reg(REG_FADE_SHAPE, {31'h1234, shp});
		for (int i = 0; i < frames; i++) begin
			if ($urandom_range(9) == 0) send_item(REQ_SELECT, 4'($urandom), rnd_samples());
			send_item(REQ_FRAME, 4'($urandom), rnd_samples());
		end
	endtask

	task automatic test_length_drop();
		// counters above a shortened length: active holds, inactive counts down
		write_reg(REG_FADE_LENGTH, 32'd40);
		send_item(REQ_SELECT, 4'd2, '0);
		for (int i = 0; i < 45; i++) send_item(REQ_FRAME, 4'd0, rnd_samples());
		write_reg(REG_FADE_LENGTH, 32'd3);
		send_item(REQ_SELECT, 4'd3, '0);
		for (int i = 0; i < 10; i++) send_item(REQ_FRAME, 4'd0, fill(16'h7fff));
		write_reg(REG_FADE_LENGTH, 32'd0);  // zero acts as one
		for (int i = 0; i < 10; i++) send_item(REQ_FRAME, 4'd0, rnd_samples());
	endtask

	task automatic test_backpressure();
		rx_hold = 1'b1;
		for (int i = 0; i < 6; i++) send_item(REQ_FRAME, 4'd0, rnd_samples());
		drain();
	endtask

	task automatic test_calm();
		rx_calm = 1'b1; tx_calm = 1'b1;
		test_fades(16'd5, 1'b0, 60);
		rx_calm = 1'b0; tx_calm = 1'b0;
	endtask

	initial begin
		arst_n <= 1'b0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_extremes();
		test_length_drop();
		test_backpressure();
		test_fades(16'd1, 1'b0, 100);
		test_fades(16'd17, 1'b1, 250);
		test_fades(16'd8, 1'b0, 250);
		test_calm();
		test_fades(16'hffff, 1'b1, 200);
		test_fades(16'd1000, 1'b0, 120);
		test_fades(16'd3, 1'b1, 150);
		drain();
		if (errors == 0) $display("** crossfade_channel_selector_top: PASSED **");
		else $display("** crossfade_channel_selector_top: FAILED **");
		$finish;
	end
endmodule
`default_nettype wire

FILE: sim.f
rtl/cfs_pkg.sv
rtl/cfs_datapath.sv
rtl/cfs_ctrl.sv
rtl/crossfade_channel_selector_top.sv
tb/sv/tb_crossfade_channel_selector_top.sv
